// ----- sv/tsg_pkg.sv -----
// Shared types and constants for the tilt scroll gesture controller.
// No dependencies; imported by every module of the block.
package tsg_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] CSR_ENABLE       = 3'd0;
   localparam logic [2:0] CSR_SELECT_THR   = 3'd1;
   localparam logic [2:0] CSR_SLOW_THR     = 3'd2;
   localparam logic [2:0] CSR_FAST_THR     = 3'd3;
   localparam logic [2:0] CSR_XFAST_THR    = 3'd4;
   localparam logic [2:0] CSR_HOLDOFF      = 3'd5;
   localparam logic [2:0] CSR_XFAST_DELAY  = 3'd6;

   // Scroll speed modes
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_SLOW  = 2'd1;
   localparam logic [1:0] MODE_FAST  = 2'd2;
   localparam logic [1:0] MODE_XFAST = 2'd3;

   // Step codes
   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_DOWN = 2'd1;
   localparam logic [1:0] STEP_UP   = 2'd2;

   typedef struct packed {
      logic        enable;
      logic [12:0] select_threshold;
      logic [12:0] slow_threshold;
      logic [12:0] fast_threshold;
      logic [12:0] extra_fast_threshold;
      logic [15:0] select_holdoff_ms;
      logic [15:0] extra_fast_delay_ms;
   } tsg_cfg_type;

   typedef struct packed {
      logic signed [12:0] tilt_x;
      logic signed [12:0] tilt_y;
      logic               during_vibration;
      logic [31:0]        stamp_ms;
   } tsg_item_type;

   typedef struct packed {
      logic       sample_used;
      logic [1:0] speed_mode;
      logic       select_fire;
      logic [1:0] step;
   } tsg_result_type;

endpackage

// ----- sv/tsg_csr.sv -----
// Configuration register file of the tilt scroll gesture controller.
// Depends on tsg_pkg for register indexes and the config struct.
module tsg_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output tsg_pkg::tsg_cfg_type cfg
);
   import tsg_pkg::*;

   tsg_cfg_type cfg_ff;
   tsg_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:      cfg_in.enable               = csr_data[0];
            CSR_SELECT_THR:  cfg_in.select_threshold     = csr_data[12:0];
            CSR_SLOW_THR:    cfg_in.slow_threshold       = csr_data[12:0];
            CSR_FAST_THR:    cfg_in.fast_threshold       = csr_data[12:0];
            CSR_XFAST_THR:   cfg_in.extra_fast_threshold = csr_data[12:0];
            CSR_HOLDOFF:     cfg_in.select_holdoff_ms    = csr_data;
            CSR_XFAST_DELAY: cfg_in.extra_fast_delay_ms  = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable               <= 1'b0;
         cfg_ff.select_threshold     <= 13'd600;
         cfg_ff.slow_threshold       <= 13'd150;
         cfg_ff.fast_threshold       <= 13'd300;
         cfg_ff.extra_fast_threshold <= 13'd500;
         cfg_ff.select_holdoff_ms    <= 16'd1000;
         cfg_ff.extra_fast_delay_ms  <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/tsg_engine.sv -----
// Gesture decision logic and gesture state (baseline, mode, tick counter, timers).
// Depends on tsg_pkg; state advances only when the top level moves an item through.
module tsg_engine #(
   parameter int unsigned SLOW_PERIOD       = 20,
   parameter int unsigned FAST_PERIOD       = 10,
   parameter int unsigned EXTRA_FAST_PERIOD = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  tsg_pkg::tsg_item_type    item,
   input  tsg_pkg::tsg_cfg_type     cfg,
   output tsg_pkg::tsg_result_type  result
);
   import tsg_pkg::*;

   logic               base_valid_ff, base_valid_in;
   logic signed [12:0] base_x_ff, base_x_in;
   logic signed [12:0] base_y_ff, base_y_in;
   logic [1:0]         mode_ff, mode_in;
   logic [7:0]         tick_ff, tick_in;
   logic [31:0]        fast_start_ff, fast_start_in;
   logic [31:0]        last_sel_ff, last_sel_in;

   logic signed [13:0] dx, dy;
   logic [13:0]        mag_x, mag_y;
   logic signed [14:0] dy_w, fth_w, sth_w;
   logic               sel_hit, fast_pos, slow_pos, fast_neg, slow_neg;
   logic               holdoff_done, in_fast, xfast_ok;
   logic [31:0]        start_f, since_sel, since_fast;
   logic [1:0]         fast_mode;
   logic [7:0]         period, tick_inc;
   logic               tick_hit;
   logic               scroll;
   logic [1:0]         scroll_mode;

   always_comb begin
      dx    = 14'(item.tilt_x) - 14'(base_x_ff);
      dy    = 14'(item.tilt_y) - 14'(base_y_ff);
      mag_x = dx[13] ? 14'(-dx) : 14'(dx);
      mag_y = dy[13] ? 14'(-dy) : 14'(dy);
      dy_w  = 15'(dy);
      fth_w = $signed({2'b00, cfg.fast_threshold});
      sth_w = $signed({2'b00, cfg.slow_threshold});

      sel_hit  = mag_x > {1'b0, cfg.select_threshold};
      fast_pos = dy_w > fth_w;
      slow_pos = dy_w > sth_w;
      fast_neg = dy_w < -fth_w;
      slow_neg = dy_w < -sth_w;

      since_sel    = item.stamp_ms - last_sel_ff;
      holdoff_done = since_sel > {16'd0, cfg.select_holdoff_ms};

      // fast region: keep start time if already fast, else start now
      in_fast    = (mode_ff == MODE_FAST) || (mode_ff == MODE_XFAST);
      start_f    = in_fast ? fast_start_ff : item.stamp_ms;
      since_fast = item.stamp_ms - start_f;
      xfast_ok   = (mag_y > {1'b0, cfg.extra_fast_threshold}) &&
                   (since_fast >= {16'd0, cfg.extra_fast_delay_ms});
      fast_mode  = xfast_ok ? MODE_XFAST : (in_fast ? mode_ff : MODE_FAST);

      scroll      = fast_pos || slow_pos || fast_neg || slow_neg;
      scroll_mode = (fast_pos || (!slow_pos && fast_neg)) ? fast_mode : MODE_SLOW;

      // period follows the mode after this sample's update
      case (scroll_mode)
         MODE_SLOW: period = 8'(SLOW_PERIOD);
         MODE_FAST: period = 8'(FAST_PERIOD);
         default:   period = 8'(EXTRA_FAST_PERIOD);
      endcase
      tick_inc = tick_ff + 8'd1;
      tick_hit = tick_inc >= period;

      base_valid_in = base_valid_ff;
      base_x_in     = base_x_ff;
      base_y_in     = base_y_ff;
      mode_in       = mode_ff;
      tick_in       = tick_ff;
      fast_start_in = fast_start_ff;
      last_sel_in   = last_sel_ff;
      result.step        = STEP_NONE;
      result.select_fire = 1'b0;
      result.sample_used = 1'b0;

      if (cfg.enable && !item.during_vibration) begin
         if (!base_valid_ff) begin
            base_valid_in = 1'b1;
            base_x_in     = item.tilt_x;
            base_y_in     = item.tilt_y;
         end else begin
            result.sample_used = 1'b1;
            if (sel_hit) begin
               if (holdoff_done) begin
                  result.select_fire = 1'b1;
                  last_sel_in        = item.stamp_ms;
               end
            end else if (scroll) begin
               mode_in       = scroll_mode;
               fast_start_in = (scroll_mode == MODE_SLOW) ? 32'd0 : start_f;
               tick_in       = tick_hit ? tick_inc - period : tick_inc;
               if (tick_hit) begin
                  result.step = (fast_pos || slow_pos) ? STEP_DOWN : STEP_UP;
               end
            end else begin
               mode_in       = MODE_IDLE;
               tick_in       = 8'd0;
               fast_start_in = 32'd0;
            end
         end
      end
      result.speed_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_valid_ff <= 1'b0;
         mode_ff       <= MODE_IDLE;
         tick_ff       <= 8'd0;
         fast_start_ff <= 32'd0;
         last_sel_ff   <= 32'd0;
      end else if (advance) begin
         base_valid_ff <= base_valid_in;
         mode_ff       <= mode_in;
         tick_ff       <= tick_in;
         fast_start_ff <= fast_start_in;
         last_sel_ff   <= last_sel_in;
      end
   end

   // Baseline is only read once base_valid_ff is set
   always_ff @(posedge clock) begin
      if (advance) begin
         base_x_ff <= base_x_in;
         base_y_ff <= base_y_in;
      end
   end

endmodule

// ----- sv/tilt_scroll_gesture_controller.sv -----
// Top level of the tilt scroll gesture controller: stream ports, input and
// result registers. Depends on tsg_pkg, tsg_csr and tsg_engine.
//
// Usage:
//   req_*  : one accelerometer sample per transfer. tdata holds tilt_x,
//            tilt_y and stamp_ms; tuser carries the vibration flag.
//   rsp_*  : exactly one result per sample, in order: step, select_fire,
//            speed_mode, sample_used.
//   csr_*  : register writes (index, data); always ready. Write only while
//            no sample is in flight.
// Path: a sample accepted into the input register is handled by the engine and
//   presented on rsp_* once it moves into the result register.
// Throughput: one sample per cycle while rsp_tready is high. The gesture state
//   lives in the engine and is updated in the same cycle a sample moves from the
//   input register into the result register, so the next sample always sees it.
// Stall: when rsp_tready is low a full result register holds; the input register
//   still takes one more sample if empty, then req_tready drops until the result moves.
// Reset: synchronous, active high. Registers return to their defaults, the
//   baseline is forgotten, mode goes idle, counters and timestamps clear.
module tilt_scroll_gesture_controller #(
   parameter int unsigned SLOW_PERIOD       = 20,
   parameter int unsigned FAST_PERIOD       = 10,
   parameter int unsigned EXTRA_FAST_PERIOD = 4
) (
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [12:0] tilt_x, [25:13] tilt_y, [57:26] stamp_ms, rest 0
   input  logic        req_tuser,  // [0] during_vibration
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [1:0] step, [2] select_fire, [4:3] speed_mode,
                                   // [5] sample_used, rest 0
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tsg_pkg::*;

   tsg_cfg_type    cfg;
   tsg_item_type   item_ff;
   logic           item_valid_ff;
   tsg_result_type result;
   tsg_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           out_free;
   logic           advance;

   assign csr_ready = 1'b1;

   tsg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // result register is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.tilt_x           <= $signed(req_tdata[12:0]);
         item_ff.tilt_y           <= $signed(req_tdata[25:13]);
         item_ff.stamp_ms         <= req_tdata[57:26];
         item_ff.during_vibration <= req_tuser;
      end
   end

   tsg_engine #(
      .SLOW_PERIOD       (SLOW_PERIOD),
      .FAST_PERIOD       (FAST_PERIOD),
      .EXTRA_FAST_PERIOD (EXTRA_FAST_PERIOD)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

`ifndef ASSERT_OFF
   // a select and a scroll step never come out of the same sample
   a_fire_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.select_fire |-> rsp_ff.step == STEP_NONE)
      else $error("select and step in one result");

   // any action implies the sample was used
   a_action_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.select_fire || rsp_ff.step != STEP_NONE)
      |-> rsp_ff.sample_used)
      else $error("action from an unused sample");

   // a scroll step leaves the block in a scrolling mode
   a_step_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.step != STEP_NONE |-> rsp_ff.speed_mode != MODE_IDLE)
      else $error("step reported with idle mode");

   // a held input item stays held until the result register frees up
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !out_free |=> item_valid_ff && $stable(item_ff))
      else $error("input item lost during stall");
`endif

endmodule
